@@ rtl/soft_timer_slot_table_unit_assert.svh @@
// Assertion macros shared by the soft timer slot table RTL.
`ifndef SOFT_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH
`define SOFT_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("soft timer slot table: implication check failed");

// Next-cycle implication, disabled during reset.
`define STST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soft timer slot table: next-cycle check failed");

`endif

@@ rtl/stst_pkg.sv @@
// Shared constants, codes and control types of the soft timer slot table.
`default_nettype none

package stst_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OP_W      = 2;
   localparam int WORD_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int KIND_W    = 3;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [KIND_W-1:0] KIND_CREATED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

   typedef struct packed {
      logic              accept;
      logic              tick_inc;
      logic              idx_clear;
      logic              idx_next;
      logic              slot_create;
      logic              slot_delete;
      logic              slot_expire;
      logic              rsp_load;
      logic [KIND_W-1:0] rsp_kind;
   } stst_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            entry_valid;
      logic            entry_due;
      logic            idx_last;
   } stst_sts_type;

endpackage

`default_nettype wire

@@ rtl/stst_req_if.sv @@
// Request channel interface of the soft timer slot table.
`default_nettype none

interface stst_req_if;
   import stst_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [WORD_W-1:0] timeout;
   logic [SLOT_W-1:0] slot;
   logic [WORD_W-1:0] callback_id;
   logic [WORD_W-1:0] argument_id;

   modport source (output valid, output operation, output timeout, output slot,
                   output callback_id, output argument_id, input ready);
   modport sink (input valid, input operation, input timeout, input slot,
                 input callback_id, input argument_id, output ready);
endinterface

`default_nettype wire

@@ rtl/stst_rsp_if.sv @@
// Response channel interface of the soft timer slot table.
`default_nettype none

interface stst_rsp_if;
   import stst_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot_index;
   logic [WORD_W-1:0] fired_callback;
   logic [WORD_W-1:0] fired_argument;
   logic [WORD_W-1:0] tick_count;
   logic              last;

   modport source (output valid, output kind, output slot_index, output fired_callback,
                   output fired_argument, output tick_count, output last, input ready);
   modport sink (input valid, input kind, input slot_index, input fired_callback,
                 input fired_argument, input tick_count, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/soft_timer_slot_table_unit.sv @@
// Soft timer slot table top level: channel wiring of controller and datapath, plus checks.
//
// req_ch carries one operation per item: tick, create or delete (code 3 is dropped with
// no result). rsp_ch returns result items; the final result of each request has last set.
// A create searches the sixteen slots from slot 0 for the lowest free one, one slot per
// cycle, and answers created or table full. A delete frees the named slot and answers deleted.
// A tick bumps the counter, then visits every slot in order, one per cycle, emitting an
// expired item for each due slot and a tick-done item at the end.
// The search and the scan share the single slot-walk index.
// One request is in flight at a time; req_ch.ready is high only between requests.
// Results leave through one output register; while it holds an item and rsp_ch.ready
// is low, the scan or search holds at the slot that needs to report, and resumes once
// the item is taken. Synchronous reset zeroes the tick counter and marks every slot
// free; stored slot contents are left as they are, since a free slot is never reported.
`default_nettype none
`include "soft_timer_slot_table_unit_assert.svh"

module soft_timer_slot_table_unit (
   input wire logic clock,
   input wire logic reset,
   stst_req_if.sink   req_ch,
   stst_rsp_if.source rsp_ch
);
   import stst_pkg::*;

   stst_cmd_type cmd;
   stst_sts_type sts;
   logic         ctl_req_ready;
   logic         ctl_rsp_valid;
   logic         expire_load;
   logic         expire_shown;

   stst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_req_ready),
      .rsp_valid (ctl_rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stst_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_ch.operation),
      .req_timeout        (req_ch.timeout),
      .req_slot           (req_ch.slot),
      .req_callback_id    (req_ch.callback_id),
      .req_argument_id    (req_ch.argument_id),
      .rsp_kind           (rsp_ch.kind),
      .rsp_slot_index     (rsp_ch.slot_index),
      .rsp_fired_callback (rsp_ch.fired_callback),
      .rsp_fired_argument (rsp_ch.fired_argument),
      .rsp_tick_count     (rsp_ch.tick_count),
      .rsp_last           (rsp_ch.last)
   );

   assign req_ch.ready = ctl_req_ready;
   assign rsp_ch.valid = ctl_rsp_valid;

   assign expire_load  = cmd.rsp_load && cmd.rsp_kind == KIND_EXPIRED;
   assign expire_shown = rsp_ch.valid && rsp_ch.kind == KIND_EXPIRED;

   `STST_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_ch.valid || rsp_ch.ready)
   `STST_ASSERT_IMP(a_expire_due, clock, reset, expire_load, sts.entry_valid && sts.entry_due)
   `STST_ASSERT_NXT(a_load_shows, clock, reset, cmd.rsp_load, rsp_ch.valid)
   `STST_ASSERT_IMP(a_expire_not_last, clock, reset, expire_shown, !rsp_ch.last)

endmodule

`default_nettype wire

@@ rtl/stst_datapath.sv @@
// Datapath of the soft timer slot table: tick counter, slot storage, scan index, result register.
`default_nettype none

module stst_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stst_pkg::stst_cmd_type        cmd,
   output stst_pkg::stst_sts_type             sts,
   input  wire logic [stst_pkg::OP_W-1:0]     req_operation,
   input  wire logic [stst_pkg::WORD_W-1:0]   req_timeout,
   input  wire logic [stst_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [stst_pkg::WORD_W-1:0]   req_callback_id,
   input  wire logic [stst_pkg::WORD_W-1:0]   req_argument_id,
   output logic      [stst_pkg::KIND_W-1:0]   rsp_kind,
   output logic      [stst_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic      [stst_pkg::WORD_W-1:0]   rsp_fired_callback,
   output logic      [stst_pkg::WORD_W-1:0]   rsp_fired_argument,
   output logic      [stst_pkg::WORD_W-1:0]   rsp_tick_count,
   output logic                               rsp_last
);
   import stst_pkg::*;

   logic [WORD_W-1:0]    timeout_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [WORD_W-1:0]    callback_id_ff;
   logic [WORD_W-1:0]    argument_id_ff;
   logic [WORD_W-1:0]    tick_ff, tick_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [WORD_W-1:0]    deadline_ff [NUM_SLOTS];
   logic [WORD_W-1:0]    callback_ff [NUM_SLOTS];
   logic [WORD_W-1:0]    argument_ff [NUM_SLOTS];

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [SLOT_W-1:0]    slot_index_ff, slot_index_in;
   logic [WORD_W-1:0]    fired_callback_ff, fired_callback_in;
   logic [WORD_W-1:0]    fired_argument_ff, fired_argument_in;
   logic [WORD_W-1:0]    tick_count_ff;
   logic                 last_ff, last_in;

   logic [IDX_W-1:0]     del_idx;
   logic                 del_hit;

   assign del_idx = IDX_W'(slot_ff);
   assign del_hit = {{(WORD_W-SLOT_W){1'b0}}, slot_ff} < WORD_W'(NUM_SLOTS);

   always_comb begin
      sts.op          = req_operation;
      sts.entry_valid = valid_ff[idx_ff];
      sts.entry_due   = tick_ff >= deadline_ff[idx_ff];
      sts.idx_last    = idx_ff == IDX_W'(NUM_SLOTS - 1);
   end

   always_comb begin
      tick_in  = cmd.tick_inc ? tick_ff + WORD_W'(1) : tick_ff;
      idx_in   = cmd.idx_clear ? '0 : (cmd.idx_next ? idx_ff + IDX_W'(1) : idx_ff);
      valid_in = valid_ff;
      if (cmd.slot_create) begin
         valid_in[idx_ff] = 1'b1;
      end
      if (cmd.slot_expire) begin
         valid_in[idx_ff] = 1'b0;
      end
      if (cmd.slot_delete && del_hit) begin
         valid_in[del_idx] = 1'b0;
      end
   end

   // Result fields for the kind chosen by the controller.
   always_comb begin
      kind_in           = cmd.rsp_kind;
      slot_index_in     = '0;
      fired_callback_in = '0;
      fired_argument_in = '0;
      last_in           = 1'b1;
      unique case (cmd.rsp_kind)
         KIND_CREATED: begin
            slot_index_in = SLOT_W'(idx_ff);
         end
         KIND_DELETED: begin
            slot_index_in = slot_ff;
         end
         KIND_EXPIRED: begin
            slot_index_in     = SLOT_W'(idx_ff);
            fired_callback_in = callback_ff[idx_ff];
            fired_argument_in = argument_ff[idx_ff];
            last_in           = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= '0;
      end else begin
         tick_ff  <= tick_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         timeout_ff     <= req_timeout;
         slot_ff        <= req_slot;
         callback_id_ff <= req_callback_id;
         argument_id_ff <= req_argument_id;
      end
      if (cmd.slot_create) begin
         deadline_ff[idx_ff] <= tick_ff + timeout_ff;
         callback_ff[idx_ff] <= callback_id_ff;
         argument_ff[idx_ff] <= argument_id_ff;
      end
      if (cmd.rsp_load) begin
         kind_ff           <= kind_in;
         slot_index_ff     <= slot_index_in;
         fired_callback_ff <= fired_callback_in;
         fired_argument_ff <= fired_argument_in;
         tick_count_ff     <= tick_ff;
         last_ff           <= last_in;
      end
   end

   assign rsp_kind           = kind_ff;
   assign rsp_slot_index     = slot_index_ff;
   assign rsp_fired_callback = fired_callback_ff;
   assign rsp_fired_argument = fired_argument_ff;
   assign rsp_tick_count     = tick_count_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

@@ rtl/stst_controller.sv @@
// Controller of the soft timer slot table: sequences tick scans, slot searches and result hand-off.
`default_nettype none

module stst_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire stst_pkg::stst_sts_type sts,
   output stst_pkg::stst_cmd_type      cmd
);
   import stst_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_TICK_DONE = 3'd2;
   localparam logic [2:0] S_FIND      = 3'd3;
   localparam logic [2:0] S_DELETE    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_load;

   // The result register takes a new item when empty or being drained.
   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = state_ff == S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept    = 1'b1;
               cmd.idx_clear = 1'b1;
               unique case (sts.op)
                  OP_TICK: begin
                     cmd.tick_inc = 1'b1;
                     state_in     = S_SCAN;
                  end
                  OP_CREATE: state_in = S_FIND;
                  OP_DELETE: state_in = S_DELETE;
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (sts.entry_valid && sts.entry_due) begin
               // Hold on a due slot until the result register frees up.
               if (can_load) begin
                  cmd.rsp_load    = 1'b1;
                  cmd.rsp_kind    = KIND_EXPIRED;
                  cmd.slot_expire = 1'b1;
                  cmd.idx_next    = 1'b1;
                  if (sts.idx_last) begin
                     state_in = S_TICK_DONE;
                  end
               end
            end else begin
               cmd.idx_next = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_TICK_DONE;
               end
            end
         end
         S_TICK_DONE: begin
            if (can_load) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = KIND_TICK_DONE;
               state_in     = S_IDLE;
            end
         end
         S_FIND: begin
            if (!sts.entry_valid) begin
               if (can_load) begin
                  cmd.rsp_load    = 1'b1;
                  cmd.rsp_kind    = KIND_CREATED;
                  cmd.slot_create = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (sts.idx_last) begin
               if (can_load) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = KIND_FULL;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         S_DELETE: begin
            if (can_load) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_kind    = KIND_DELETED;
               cmd.slot_delete = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ bench/slot_table_monitor.sv @@
`timescale 1ns / 100ps
// Channel monitor for the slot table: mirrors the timer table and checks every result item.
module slot_table_monitor
   import stst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   stst_req_if  req_mon,
   stst_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   result_count,
   output int   expiry_count,
   output int   full_count
);

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot_index;
      logic [WORD_W-1:0] fired_callback;
      logic [WORD_W-1:0] fired_argument;
      logic [WORD_W-1:0] tick_count;
      logic              last;
   } timer_result_type;

   timer_result_type  awaited_results[$];
   logic [WORD_W-1:0] tick_now;
   logic              armed       [NUM_SLOTS];
   logic [WORD_W-1:0] deadline    [NUM_SLOTS];
   logic [WORD_W-1:0] callback_of [NUM_SLOTS];
   logic [WORD_W-1:0] argument_of [NUM_SLOTS];

   function automatic void queue_result(input logic [KIND_W-1:0] kind, input int idx,
                                        input logic [WORD_W-1:0] cb,
                                        input logic [WORD_W-1:0] arg, input logic last);
      timer_result_type r;
      r.kind           = kind;
      r.slot_index     = idx[SLOT_W-1:0];
      r.fired_callback = cb;
      r.fired_argument = arg;
      r.tick_count     = tick_now;
      r.last           = last;
      awaited_results.push_back(r);
   endfunction

   function automatic void release_slot(input int idx);
      armed[idx]       = 1'b0;
      deadline[idx]    = '0;
      callback_of[idx] = '0;
      argument_of[idx] = '0;
   endfunction

   function automatic void predict_request(input logic [OP_W-1:0] op,
                                           input logic [WORD_W-1:0] timeout,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [WORD_W-1:0] cb,
                                           input logic [WORD_W-1:0] arg);
      bit placed;
      placed = 1'b0;
      case (op)
         OP_TICK: begin
            tick_now = tick_now + WORD_W'(1);
            // plain unsigned compare, the deadline may have wrapped below the counter
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (armed[i] && tick_now >= deadline[i]) begin
                  queue_result(KIND_EXPIRED, i, callback_of[i], argument_of[i], 1'b0);
                  release_slot(i);
               end
            end
            queue_result(KIND_TICK_DONE, 0, '0, '0, 1'b1);
         end
         OP_CREATE: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!placed && !armed[i]) begin
                  armed[i]       = 1'b1;
                  callback_of[i] = cb;
                  argument_of[i] = arg;
                  deadline[i]    = tick_now + timeout;
                  queue_result(KIND_CREATED, i, '0, '0, 1'b1);
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               queue_result(KIND_FULL, 0, '0, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (int'(slot) < NUM_SLOTS) begin
               release_slot(int'(slot));
            end
            queue_result(KIND_DELETED, int'(slot), '0, '0, 1'b1);
         end
         default: ;  // drop the unused code, no result
      endcase
   endfunction

   function automatic int field_mismatch(input string name, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         tick_now = '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            release_slot(i);
         end
         awaited_results.delete();
      end else begin
         // compare first: a result leaving now belongs to an earlier item
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (rsp_mon.kind == KIND_EXPIRED) begin
               expiry_count++;
            end
            if (rsp_mon.kind == KIND_FULL) begin
               full_count++;
            end
            if (awaited_results.size() == 0) begin
               $error("result item with nothing awaited: kind %0d slot %0d",
                      rsp_mon.kind, rsp_mon.slot_index);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               fail_count += field_mismatch("kind", WORD_W'(want.kind),
                                            WORD_W'(rsp_mon.kind));
               fail_count += field_mismatch("slot_index", WORD_W'(want.slot_index),
                                            WORD_W'(rsp_mon.slot_index));
               fail_count += field_mismatch("fired_callback", want.fired_callback,
                                            rsp_mon.fired_callback);
               fail_count += field_mismatch("fired_argument", want.fired_argument,
                                            rsp_mon.fired_argument);
               fail_count += field_mismatch("tick_count", want.tick_count, rsp_mon.tick_count);
               fail_count += field_mismatch("last", WORD_W'(want.last),
                                            WORD_W'(rsp_mon.last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.operation, req_mon.timeout, req_mon.slot,
                            req_mon.callback_id, req_mon.argument_id);
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Bench top for the slot table: clock, reset, request and result traffic, and the verdict.
module testbench;
   import stst_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 200;
   localparam int MAX_GAP         = 18;
   localparam int HOLD_OFF        = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles;
   int   requests;
   int   ignored;
   int   fail_count;
   int   outstanding;
   int   result_count;
   int   expiry_count;
   int   full_count;

   stst_req_if req_if ();
   stst_rsp_if rsp_if ();

   soft_timer_slot_table_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   slot_table_monitor monitor (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .result_count (result_count),
      .expiry_count (expiry_count),
      .full_count   (full_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results still awaited", cycles, outstanding);
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic offer_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] timeout,
                                input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] cb,
                                input logic [WORD_W-1:0] arg);
      int gap;
      // every fourth run of 16 items goes back to back
      gap = (((requests + ignored) / 16) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.timeout     <= timeout;
      req_if.slot        <= slot;
      req_if.callback_id <= cb;
      req_if.argument_id <= arg;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (op == OP_UNUSED) begin
         ignored++;
      end else begin
         requests++;
      end
   endtask

   // result side: random or no stall before each item, one long hold-off to back up the input
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 60) begin
            stall = HOLD_OFF;
         end else if ((taken / 24) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int                pick;
      int                directed;
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] timeout;
      req_if.valid       <= 1'b0;
      req_if.operation   <= OP_TICK;
      req_if.timeout     <= '0;
      req_if.slot        <= '0;
      req_if.callback_id <= '0;
      req_if.argument_id <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      offer_request(OP_TICK, '0, '0, '0, '0);
      offer_request(OP_CREATE, 32'd0, 4'hF, 32'hFFFF_FFFF, 32'h0);
      // deadline sum wraps to zero
      offer_request(OP_CREATE, 32'hFFFF_FFFF, 4'h0, 32'h0, 32'hFFFF_FFFF);
      offer_request(OP_CREATE, 32'd1, 4'h5, $urandom(), $urandom());
      offer_request(OP_UNUSED, $urandom(), 4'hA, $urandom(), $urandom());
      // all three fire in one scan
      offer_request(OP_TICK, $urandom(), SLOT_W'($urandom_range(0, 15)), $urandom(),
                    $urandom());
      for (int i = 0; i < NUM_SLOTS; i++) begin
         offer_request(OP_CREATE, i % 4, SLOT_W'($urandom_range(0, 15)), $urandom(),
                       $urandom());
      end
      offer_request(OP_CREATE, 32'd7, 4'h0, $urandom(), $urandom());
      offer_request(OP_DELETE, '0, 4'd15, '0, '0);
      offer_request(OP_DELETE, '0, 4'd15, '0, '0);
      offer_request(OP_TICK, '0, '0, '0, '0);
      directed = requests;

      while (requests < directed + RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            op = OP_UNUSED;
         end else if (pick < 34) begin
            op = OP_TICK;
         end else if (pick < 76) begin
            op = OP_CREATE;
         end else begin
            op = OP_DELETE;
         end
         case ($urandom_range(0, 9))
            0:       timeout = $urandom();
            1:       timeout = 32'hFFFF_FFFF - $urandom_range(0, 3);
            2, 3:    timeout = $urandom_range(0, 64);
            default: timeout = $urandom_range(0, 8);
         endcase
         offer_request(op, timeout, SLOT_W'($urandom_range(0, 15)), $urandom(), $urandom());
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d dropped unused-code items, %0d results checked",
               requests, ignored, result_count);
      $display("of those, %0d expiries and %0d table-full answers", expiry_count, full_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
